// ===== rtl/core/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types, constants and the per-step channel layout of the RC receiver
// frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfd_pkg;

    localparam int LONG_FRAME_BYTES  = 25;
    localparam int SHORT_FRAME_BYTES = 18;
    localparam int COUNT_LIMIT       = 50;
    localparam int STORE_AW          = 5;
    localparam int COUNT_W           = 6;
    localparam int STEP_W            = 5;
    localparam int CHAN_BITS         = 11;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE = 8'h00;

    localparam logic signed [11:0] OFFSET_LONG  = -12'sd1023;
    localparam logic signed [11:0] OFFSET_SHORT = -12'sd1024;
    localparam logic signed [11:0] OFFSET_DIAL  = 12'sd1024;

    localparam logic [1:0] SW_NONE = 2'd3;
    localparam logic [1:0] SW_POS0 = 2'd0;
    localparam logic [1:0] SW_POS1 = 2'd1;
    localparam logic [1:0] SW_POS2 = 2'd2;

    localparam logic [1:0] SW_CODE_LOW  = 2'd1;
    localparam logic [1:0] SW_CODE_MID  = 2'd3;
    localparam logic [1:0] SW_CODE_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CALC,
        ST_SEND
    } state_t;

    typedef enum logic [2:0] {
        OP_HDR,
        OP_FTR,
        OP_CENTER_LONG,
        OP_CENTER_SW,
        OP_RAW,
        OP_CENTER_SHORT,
        OP_NEG_SHORT,
        OP_SWITCH
    } op_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } rcfd_in_t;

    typedef struct packed {
        logic               frame_kind;
        logic [3:0]         channel_index;
        logic signed [11:0] channel_value;
        logic [1:0]         switch_position;
        logic               last_channel;
    } rcfd_out_t;

    typedef struct packed {
        logic [STORE_AW-1:0] base;
        logic [2:0]          off;
        op_t                 op;
        logic [3:0]          chan;
        logic                last;
    } step_desc_t;

    // Where each step's three-byte window starts, the bit offset of the field
    // inside it, and what is done with the field.
    function automatic step_desc_t step_desc(logic kind, logic [STEP_W-1:0] step);
        step_desc_t d;
        logic [3:0] ch;
        logic [7:0] bitpos;
        d.base = '0;
        d.off  = '0;
        d.op   = OP_RAW;
        d.chan = '0;
        d.last = 1'b0;
        ch     = 4'(step - STEP_W'(2));
        bitpos = 8'(ch) * 8'(CHAN_BITS);
        if (!kind) begin
            if (step == STEP_W'(0)) begin
                d.op = OP_HDR;
            end else if (step == STEP_W'(1)) begin
                // Window covers the last three bytes; the footer is the top one.
                d.base = STORE_AW'(LONG_FRAME_BYTES - 3);
                d.op   = OP_FTR;
            end else begin
                d.base = STORE_AW'(1) + STORE_AW'(bitpos[7:3]);
                d.off  = bitpos[2:0];
                d.chan = ch;
                d.last = (ch == 4'd15);
                if (ch >= 4'd6 && ch <= 4'd9) begin
                    d.op = OP_CENTER_SW;
                end else if (ch < 4'd10) begin
                    d.op = OP_CENTER_LONG;
                end else begin
                    d.op = OP_RAW;
                end
            end
        end else begin
            d.chan = step[3:0];
            case (step)
                STEP_W'(0): begin
                    d.base = STORE_AW'(0);
                    d.off  = 3'd0;
                    d.op   = OP_CENTER_SHORT;
                end
                STEP_W'(1): begin
                    d.base = STORE_AW'(1);
                    d.off  = 3'd3;
                    d.op   = OP_CENTER_SHORT;
                end
                STEP_W'(2): begin
                    d.base = STORE_AW'(4);
                    d.off  = 3'd1;
                    d.op   = OP_CENTER_SHORT;
                end
                STEP_W'(3): begin
                    d.base = STORE_AW'(2);
                    d.off  = 3'd6;
                    d.op   = OP_CENTER_SHORT;
                end
                STEP_W'(4): begin
                    d.base = STORE_AW'(16);
                    d.off  = 3'd0;
                    d.op   = OP_NEG_SHORT;
                end
                STEP_W'(5): begin
                    d.base = STORE_AW'(5);
                    d.off  = 3'd6;
                    d.op   = OP_SWITCH;
                end
                STEP_W'(6): begin
                    d.base = STORE_AW'(5);
                    d.off  = 3'd4;
                    d.op   = OP_SWITCH;
                    d.last = 1'b1;
                end
                default: begin
                    d.op   = OP_RAW;
                    d.last = 1'b1;
                end
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rcfd_ram.sv =====
// ----------------------------------------------------------------------------
// rcfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rc_receiver_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder
// Stores receiver bytes and, on an idle-line event, decodes a 25-byte or an
// 18-byte frame into a run of channel results.
// ----------------------------------------------------------------------------
//  channel  ports                      payload     transaction
//  input    s_valid s_ready s_data     rcfd_in_t   one byte or one idle event
//  output   m_valid m_ready m_data     rcfd_out_t  one decoded channel
//
// After an idle event each result fetches its three-byte window through the
// single RAM read port, one byte at a time, then passes through the
// shift-and-add unit into the output register and is held until taken.
// The input is not ready until the last result is taken. Reset clears the
// byte count and the sequencer; the frame store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_receiver_frame_decoder (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rcfd_pkg::rcfd_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rcfd_pkg::rcfd_out_t    m_data
);

    rcfd_pkg::state_t                  state_reg, state_next;
    logic [rcfd_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic                              kind_reg, kind_next;
    logic [rcfd_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [1:0]                        phase_reg, phase_next;
    logic [23:0]                       window_reg, window_next;
    rcfd_pkg::rcfd_out_t               out_reg, out_next;

    rcfd_pkg::step_desc_t              desc;
    logic                              ram_we;
    logic [rcfd_pkg::STORE_AW-1:0]     ram_raddr;
    logic [7:0]                        ram_rdata;
    logic                              frame_long, frame_short;
    logic                              check_fail;
    logic [23:0]                       shifted;
    logic [10:0]                       raw;
    logic signed [11:0]                add_a, add_b, add_sum;
    logic                              add_cin;
    logic [1:0]                        sw_pos;

    assign desc        = rcfd_pkg::step_desc(kind_reg, step_reg);
    assign frame_long  = (count_reg == rcfd_pkg::COUNT_W'(rcfd_pkg::LONG_FRAME_BYTES));
    assign frame_short = (count_reg == rcfd_pkg::COUNT_W'(rcfd_pkg::SHORT_FRAME_BYTES));

    assign ram_we    = s_valid && s_ready && !s_data.action
                       && (count_reg < rcfd_pkg::COUNT_W'(rcfd_pkg::LONG_FRAME_BYTES));
    assign ram_raddr = (state_reg == rcfd_pkg::ST_FETCH && phase_reg != 2'd3)
                       ? desc.base + rcfd_pkg::STORE_AW'(phase_reg) : '0;

    rcfd_ram #(
        .WIDTH (8),
        .DEPTH (rcfd_pkg::LONG_FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[rcfd_pkg::STORE_AW-1:0]),
        .wdata (s_data.rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared datapath: field extraction by shift, then one adder.
    assign shifted = window_reg >> desc.off;
    assign raw     = shifted[rcfd_pkg::CHAN_BITS-1:0];

    always_comb begin
        add_a   = $signed({1'b0, raw});
        add_b   = '0;
        add_cin = 1'b0;
        case (desc.op)
            rcfd_pkg::OP_CENTER_LONG,
            rcfd_pkg::OP_CENTER_SW:    add_b = rcfd_pkg::OFFSET_LONG;
            rcfd_pkg::OP_CENTER_SHORT: add_b = rcfd_pkg::OFFSET_SHORT;
            rcfd_pkg::OP_NEG_SHORT: begin
                add_a   = ~$signed({1'b0, raw});
                add_b   = rcfd_pkg::OFFSET_DIAL;
                add_cin = 1'b1;
            end
            rcfd_pkg::OP_SWITCH:       add_a = $signed({10'b0, raw[1:0]});
            default:                   add_b = '0;
        endcase
    end

    assign add_sum = add_a + add_b + $signed({11'b0, add_cin});

    always_comb begin
        sw_pos = rcfd_pkg::SW_NONE;
        case (desc.op)
            rcfd_pkg::OP_CENTER_SW: begin
                if (add_sum == 12'sd0) begin
                    sw_pos = rcfd_pkg::SW_POS1;
                end else if (add_sum[11]) begin
                    sw_pos = rcfd_pkg::SW_POS0;
                end else begin
                    sw_pos = rcfd_pkg::SW_POS2;
                end
            end
            rcfd_pkg::OP_SWITCH: begin
                case (raw[1:0])
                    rcfd_pkg::SW_CODE_LOW:  sw_pos = rcfd_pkg::SW_POS0;
                    rcfd_pkg::SW_CODE_MID:  sw_pos = rcfd_pkg::SW_POS1;
                    rcfd_pkg::SW_CODE_HIGH: sw_pos = rcfd_pkg::SW_POS2;
                    default:                sw_pos = rcfd_pkg::SW_NONE;
                endcase
            end
            default: sw_pos = rcfd_pkg::SW_NONE;
        endcase
    end

    always_comb begin
        check_fail = 1'b0;
        case (desc.op)
            rcfd_pkg::OP_HDR: check_fail = (window_reg[7:0] != rcfd_pkg::HEADER_BYTE);
            rcfd_pkg::OP_FTR: check_fail = (window_reg[23:16] != rcfd_pkg::FOOTER_BYTE);
            default:          check_fail = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rcfd_pkg::ST_IDLE: begin
                if (s_valid && s_data.action && (frame_long || frame_short)) begin
                    state_next = rcfd_pkg::ST_FETCH;
                end
            end
            rcfd_pkg::ST_FETCH: begin
                if (phase_reg == 2'd3) begin
                    state_next = rcfd_pkg::ST_CALC;
                end
            end
            rcfd_pkg::ST_CALC: begin
                if (desc.op == rcfd_pkg::OP_HDR || desc.op == rcfd_pkg::OP_FTR) begin
                    state_next = check_fail ? rcfd_pkg::ST_IDLE : rcfd_pkg::ST_FETCH;
                end else begin
                    state_next = rcfd_pkg::ST_SEND;
                end
            end
            rcfd_pkg::ST_SEND: begin
                if (m_ready) begin
                    state_next = out_reg.last_channel ? rcfd_pkg::ST_IDLE
                                                      : rcfd_pkg::ST_FETCH;
                end
            end
            default: state_next = rcfd_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath registers.
    always_comb begin
        s_ready     = (state_reg == rcfd_pkg::ST_IDLE);
        m_valid     = (state_reg == rcfd_pkg::ST_SEND);
        m_data      = out_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        window_next = window_reg;
        out_next    = out_reg;
        case (state_reg)
            rcfd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (!s_data.action) begin
                        if (count_reg < rcfd_pkg::COUNT_W'(rcfd_pkg::COUNT_LIMIT)) begin
                            count_next = count_reg + rcfd_pkg::COUNT_W'(1);
                        end
                    end else begin
                        count_next = '0;
                        kind_next  = frame_short;
                        step_next  = '0;
                        phase_next = '0;
                    end
                end
            end
            rcfd_pkg::ST_FETCH: begin
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd1:    window_next[7:0]   = ram_rdata;
                    2'd2:    window_next[15:8]  = ram_rdata;
                    2'd3:    window_next[23:16] = ram_rdata;
                    default: window_next        = window_reg;
                endcase
            end
            rcfd_pkg::ST_CALC: begin
                if (desc.op == rcfd_pkg::OP_HDR || desc.op == rcfd_pkg::OP_FTR) begin
                    step_next  = step_reg + rcfd_pkg::STEP_W'(1);
                    phase_next = '0;
                end else begin
                    out_next.frame_kind      = kind_reg;
                    out_next.channel_index   = desc.chan;
                    out_next.channel_value   = add_sum;
                    out_next.switch_position = sw_pos;
                    out_next.last_channel    = desc.last;
                end
            end
            rcfd_pkg::ST_SEND: begin
                if (m_ready) begin
                    step_next  = step_reg + rcfd_pkg::STEP_W'(1);
                    phase_next = '0;
                end
            end
            default: begin
                phase_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcfd_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        kind_reg   <= kind_next;
        step_reg   <= step_next;
        phase_reg  <= phase_next;
        window_reg <= window_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives rc_receiver_frame_decoder with byte and idle-line transactions. The
// transactions form S.BUS, DBUS and malformed frames. A scoreboard predicts
// every decoded channel from its own copy of the frame store and checks each
// result transaction in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import rcfd_pkg::*;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_IDLE  = 1'b1;
    localparam logic KIND_SBUS = 1'b0;
    localparam logic KIND_DBUS = 1'b1;

    localparam int SBUS_PAYLOAD_BYTES = 22;
    localparam int TOTAL_ITEMS        = 360;
    localparam int DRAIN_CYCLES       = 200;
    localparam int QUIET_LIMIT        = 5000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    rcfd_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    rcfd_out_t m_data;

    // Mirrors the frame store and byte count, and queues the channels that
    // each idle-line transaction should produce.
    class channel_scoreboard;
        logic [7:0]  frame_bytes [LONG_FRAME_BYTES];
        int unsigned rx_count;
        rcfd_out_t   expected_channels [$];
        int unsigned failures;
        int unsigned checked;
        int unsigned sbus_frames;
        int unsigned dbus_frames;
        int unsigned dropped_frames;

        function new();
            rx_count       = 0;
            failures       = 0;
            checked        = 0;
            sbus_frames    = 0;
            dbus_frames    = 0;
            dropped_frames = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        endfunction

        function int pending();
            return expected_channels.size();
        endfunction

        function void push_channel(logic kind, int idx, int value, logic [1:0] pos,
                                   logic last);
            rcfd_out_t r;
            r.frame_kind      = kind;
            r.channel_index   = 4'(idx);
            r.channel_value   = 12'(value);
            r.switch_position = pos;
            r.last_channel    = last;
            expected_channels.push_back(r);
        endfunction

        function logic [1:0] switch_pos(logic [1:0] code);
            case (code)
                SW_CODE_LOW:  return SW_POS0;
                SW_CODE_MID:  return SW_POS1;
                SW_CODE_HIGH: return SW_POS2;
                default:      return SW_NONE;
            endcase
        endfunction

        function void decode_sbus();
            logic [175:0] payload;
            int           raw;
            int           value;
            int           i;
            int           k;
            logic [1:0]   pos;
            if (frame_bytes[0] != HEADER_BYTE ||
                frame_bytes[LONG_FRAME_BYTES-1] != FOOTER_BYTE) begin
                dropped_frames++;
                return;
            end
            sbus_frames++;
            for (i = 0; i < SBUS_PAYLOAD_BYTES; i++) begin
                payload[8*i +: 8] = frame_bytes[i+1];
            end
            for (k = 0; k < 16; k++) begin
                raw   = int'(payload[11*k +: 11]);
                value = (k < 10) ? raw - 1023 : raw;
                pos   = SW_NONE;
                // Channels 6 to 9 double as switches, classed by the sign.
                if (k >= 6 && k <= 9) begin
                    pos = (value == 0) ? SW_POS1 : ((value > 0) ? SW_POS2 : SW_POS0);
                end
                push_channel(KIND_SBUS, k, value, pos, k == 15);
            end
        endfunction

        function void decode_dbus();
            logic [47:0] head;
            logic [1:0]  code5;
            logic [1:0]  code6;
            int          dial;
            int          i;
            dbus_frames++;
            for (i = 0; i < 6; i++) begin
                head[8*i +: 8] = frame_bytes[i];
            end
            dial  = int'({frame_bytes[17][2:0], frame_bytes[16]});
            code5 = head[47:46];
            code6 = head[45:44];
            push_channel(KIND_DBUS, 0, int'(head[0 +: 11]) - 1024, SW_NONE, 1'b0);
            push_channel(KIND_DBUS, 1, int'(head[11 +: 11]) - 1024, SW_NONE, 1'b0);
            push_channel(KIND_DBUS, 2, int'(head[33 +: 11]) - 1024, SW_NONE, 1'b0);
            push_channel(KIND_DBUS, 3, int'(head[22 +: 11]) - 1024, SW_NONE, 1'b0);
            push_channel(KIND_DBUS, 4, 1024 - dial, SW_NONE, 1'b0);
            push_channel(KIND_DBUS, 5, int'(code5), switch_pos(code5), 1'b0);
            push_channel(KIND_DBUS, 6, int'(code6), switch_pos(code6), 1'b1);
        endfunction

        function void note_rx(rcfd_in_t t);
            int unsigned n;
            if (t.action == ACT_BYTE) begin
                if (rx_count < LONG_FRAME_BYTES) frame_bytes[rx_count] = t.rx_byte;
                if (rx_count < COUNT_LIMIT) rx_count++;
            end else begin
                n        = rx_count;
                rx_count = 0;
                if (n == LONG_FRAME_BYTES) begin
                    decode_sbus();
                end else if (n == SHORT_FRAME_BYTES) begin
                    decode_dbus();
                end else begin
                    dropped_frames++;
                end
            end
        endfunction

        function void check_channel(rcfd_out_t got);
            rcfd_out_t want;
            if (expected_channels.size() == 0) begin
                $display("%0t: unexpected channel result, got kind %0d index %0d value %0d",
                         $time, got.frame_kind, got.channel_index,
                         $signed(got.channel_value));
                failures++;
                return;
            end
            want = expected_channels.pop_front();
            checked++;
            if (got.frame_kind !== want.frame_kind) begin
                $display("%0t: frame_kind mismatch, expected %0d, got %0d",
                         $time, want.frame_kind, got.frame_kind);
                failures++;
            end
            if (got.channel_index !== want.channel_index) begin
                $display("%0t: channel_index mismatch, expected %0d, got %0d",
                         $time, want.channel_index, got.channel_index);
                failures++;
            end
            if (got.channel_value !== want.channel_value) begin
                $display("%0t: channel %0d value mismatch, expected %0d, got %0d",
                         $time, want.channel_index, $signed(want.channel_value),
                         $signed(got.channel_value));
                failures++;
            end
            if (got.switch_position !== want.switch_position) begin
                $display("%0t: channel %0d switch_position mismatch, expected %0d, got %0d",
                         $time, want.channel_index, want.switch_position,
                         got.switch_position);
                failures++;
            end
            if (got.last_channel !== want.last_channel) begin
                $display("%0t: channel %0d last_channel mismatch, expected %0d, got %0d",
                         $time, want.channel_index, want.last_channel, got.last_channel);
                failures++;
            end
        endfunction
    endclass

    channel_scoreboard chans;
    int unsigned       burst_left     = 0;
    int unsigned       items_accepted = 0;
    int unsigned       quiet_cycles   = 0;

    rc_receiver_frame_decoder u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            chans.check_channel(m_data);
        end
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired, no transaction for %0d cycles",
                     $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // The receiver switches between free-running, coin-toss and mostly
    // stalled stretches.
    initial begin
        int unsigned mode;
        int unsigned len;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 60);
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Bursts of random length with random gaps in between; a gap of zero
    // keeps valid high across the burst boundary.
    task automatic put_item(input logic act, input logic [7:0] value);
        int unsigned gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid        = 1'b1;
        s_data.action  = act;
        s_data.rx_byte = value;
        do @(posedge aclk); while (!s_ready);
        chans.note_rx(s_data);
        items_accepted++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (chans.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_sbus(input logic [175:0] payload, input logic [7:0] head_byte,
                             input logic [7:0] foot_byte);
        int i;
        put_item(ACT_BYTE, head_byte);
        for (i = 0; i < SBUS_PAYLOAD_BYTES; i++) put_item(ACT_BYTE, payload[8*i +: 8]);
        put_item(ACT_BYTE, 8'($urandom));
        put_item(ACT_BYTE, foot_byte);
        put_item(ACT_IDLE, 8'($urandom));
    endtask

    task automatic send_dbus(input logic [143:0] frame);
        int i;
        for (i = 0; i < SHORT_FRAME_BYTES; i++) put_item(ACT_BYTE, frame[8*i +: 8]);
        put_item(ACT_IDLE, 8'($urandom));
    endtask

    task automatic send_noise(input int unsigned len);
        repeat (len) put_item(ACT_BYTE, 8'($urandom));
        put_item(ACT_IDLE, 8'($urandom));
    endtask

    // Channel values lean toward the ends of the range and the centre.
    function automatic logic [175:0] random_payload();
        logic [175:0] p;
        int           k;
        for (k = 0; k < 16; k++) begin
            case ($urandom_range(0, 5))
                0:       p[11*k +: 11] = 11'd0;
                1:       p[11*k +: 11] = 11'h7FF;
                2:       p[11*k +: 11] = 11'd1023;
                3:       p[11*k +: 11] = 11'($urandom_range(1021, 1025));
                default: p[11*k +: 11] = 11'($urandom);
            endcase
        end
        return p;
    endfunction

    function automatic logic [143:0] random_dbus();
        logic [143:0] f;
        int           i;
        for (i = 0; i < SHORT_FRAME_BYTES; i++) f[8*i +: 8] = 8'($urandom);
        return f;
    endfunction

    initial begin
        logic [143:0] dframe;
        logic [7:0]   bad_byte;
        int unsigned  pick;
        int unsigned  noise_lens [10];

        noise_lens = '{0, 1, 17, 19, 24, 26, 49, 50, 51, 60};
        chans   = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed frames: empty idle, channel extremes, zero-valued switches,
        // broken header and footer, all DBUS switch codes, odd lengths and a
        // saturating run of bytes.
        send_noise(0);
        send_sbus({16{11'd1023}}, HEADER_BYTE, FOOTER_BYTE);
        send_sbus({16{11'd0}}, HEADER_BYTE, FOOTER_BYTE);
        send_sbus({16{11'h7FF}}, HEADER_BYTE, FOOTER_BYTE);
        send_sbus(random_payload(), HEADER_BYTE, FOOTER_BYTE);
        send_sbus(random_payload(), 8'h0E, FOOTER_BYTE);
        send_sbus(random_payload(), HEADER_BYTE, 8'h80);
        send_dbus('0);
        send_dbus({144{1'b1}});
        dframe         = random_dbus();
        dframe[47:44]  = {SW_CODE_LOW, SW_CODE_HIGH};
        send_dbus(dframe);
        dframe         = random_dbus();
        dframe[47:44]  = {SW_CODE_MID, 2'b00};
        send_dbus(dframe);
        send_noise(17);
        send_noise(26);
        send_noise(60);
        wait_drained();

        // Random frames fill up the rest of the transaction budget.
        while (items_accepted < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                send_sbus(random_payload(), HEADER_BYTE, FOOTER_BYTE);
            end else if (pick <= 6) begin
                send_dbus(random_dbus());
            end else if (pick == 7) begin
                bad_byte = 8'($urandom);
                if ($urandom_range(0, 1) == 0) begin
                    if (bad_byte == HEADER_BYTE) bad_byte = bad_byte ^ 8'h01;
                    send_sbus(random_payload(), bad_byte, FOOTER_BYTE);
                end else begin
                    if (bad_byte == FOOTER_BYTE) bad_byte = 8'h01;
                    send_sbus(random_payload(), HEADER_BYTE, bad_byte);
                end
            end else if (pick == 8) begin
                send_noise(noise_lens[$urandom_range(0, 9)]);
            end else begin
                send_noise($urandom_range(0, 60));
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input transactions and checked %0d channel results.",
                 items_accepted, chans.checked);
        $display("Decoded %0d S.BUS and %0d DBUS frames; %0d idle events gave no result.",
                 chans.sbus_frames, chans.dbus_frames, chans.dropped_frames);
        if (chans.failures == 0 && chans.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
